### hdl/pwfc_pkg.sv
// Package for the proportional wall-following controller.
// Holds item and config types, register indexes, sine table and FSM-free helpers.
package pwfc_pkg;

  localparam int MAX_READINGS_DEF = 24;
  localparam int ANGLE_BITS_DEF   = 12;

  localparam logic [1:0] REG_CRUISE    = 2'd0;
  localparam logic [1:0] REG_TARGET    = 2'd1;
  localparam logic [1:0] REG_GAIN      = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  typedef struct packed {
    logic [12:0] reading_value;
    logic [11:0] reading_angle;
    logic        last_reading;
  } in_item_t;

  typedef struct packed {
    logic [15:0] left_speed;
    logic [15:0] right_speed;
    logic        wall_seen;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture input item
    logic accum;      // add component pair to sums
    logic clear;      // drop set state
    logic div_start;  // begin mean division
    logic div_step;   // one quotient bit
    logic div_end;    // round and sign the means
    logic sq_x;       // square mean x
    logic sqrt_start; // square mean y, add, begin root
    logic sqrt_step;  // one root bit
    logic fin_err;    // round root, form error
    logic fin_mul;    // gain times error
    logic fin_out;    // build speeds
  } cmd_t;

  typedef struct packed {
    logic last;
    logic wall;
    logic take;    // item is counted
  } status_t;

  function automatic logic [12:0] sine_table(input logic [5:0] i);
    logic [12:0] v;
    case (i)
      6'd0: v = 13'd0;     6'd1: v = 13'd201;   6'd2: v = 13'd401;
      6'd3: v = 13'd601;   6'd4: v = 13'd799;   6'd5: v = 13'd995;
      6'd6: v = 13'd1189;  6'd7: v = 13'd1380;  6'd8: v = 13'd1567;
      6'd9: v = 13'd1751;  6'd10: v = 13'd1931; 6'd11: v = 13'd2106;
      6'd12: v = 13'd2276; 6'd13: v = 13'd2440; 6'd14: v = 13'd2598;
      6'd15: v = 13'd2751; 6'd16: v = 13'd2896; 6'd17: v = 13'd3035;
      6'd18: v = 13'd3166; 6'd19: v = 13'd3290; 6'd20: v = 13'd3406;
      6'd21: v = 13'd3513; 6'd22: v = 13'd3612; 6'd23: v = 13'd3703;
      6'd24: v = 13'd3784; 6'd25: v = 13'd3857; 6'd26: v = 13'd3920;
      6'd27: v = 13'd3973; 6'd28: v = 13'd4017; 6'd29: v = 13'd4052;
      6'd30: v = 13'd4076; 6'd31: v = 13'd4091;
      default: v = 13'd4096;
    endcase
    return v;
  endfunction

endpackage

### hdl/pwfc_ctrl.sv
// Controller FSM for the wall-following controller.
// Sequences accumulation, division, root and output build. Uses pwfc_pkg.
module pwfc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  pwfc_pkg::status_t status,
  output pwfc_pkg::cmd_t    cmd
);
  import pwfc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_DEND  = 4'd4;
  localparam logic [3:0] S_SQX   = 4'd5;
  localparam logic [3:0] S_SQY   = 4'd6;
  localparam logic [3:0] S_ROOT  = 4'd7;
  localparam logic [3:0] S_ERR   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_HOLD  = 4'd11;

  localparam int DIV_STEPS  = 20;
  localparam int ROOT_STEPS = 15;

  logic [3:0] state, state_next;
  logic [4:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_HOLD);

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum  = status.take;
        state_next = status.last ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (status.wall) begin
          cmd.div_start = 1'b1;
          count_next    = '0;
          state_next    = S_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        count_next   = count + 5'd1;
        if (count == 5'(DIV_STEPS - 1)) state_next = S_DEND;
      end
      S_DEND: begin
        cmd.div_end = 1'b1;
        state_next  = S_SQX;
      end
      S_SQX: begin
        cmd.sq_x   = 1'b1;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.sqrt_start = 1'b1;
        count_next     = '0;
        state_next     = S_ROOT;
      end
      S_ROOT: begin
        cmd.sqrt_step = 1'b1;
        count_next    = count + 5'd1;
        if (count == 5'(ROOT_STEPS - 1)) state_next = S_ERR;
      end
      S_ERR: begin
        cmd.fin_err = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.fin_mul = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        cmd.fin_out = 1'b1;
        cmd.clear   = 1'b1;
        state_next  = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/pwfc_datapath.sv
// Datapath for the wall-following controller: trig, sums, divider, root, speeds.
// Driven by pwfc_ctrl commands. Uses pwfc_pkg.
module pwfc_datapath #(
  parameter int MAX_READINGS = pwfc_pkg::MAX_READINGS_DEF,
  parameter int ANGLE_BITS   = pwfc_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pwfc_pkg::in_item_t in_item,
  input  pwfc_pkg::cfg_item_t cfg_item,
  input  logic               cfg_we,
  input  pwfc_pkg::cmd_t     cmd,
  output pwfc_pkg::status_t  status,
  output pwfc_pkg::out_item_t out_item
);
  import pwfc_pkg::*;

  localparam int FB   = ANGLE_BITS - 7;
  localparam int QB   = ANGLE_BITS - 2;
  localparam int CW   = $clog2(MAX_READINGS + 1);

  // config registers
  logic [15:0] cruise_speed, steer_gain;
  logic [12:0] target_distance, wall_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cruise_speed    <= 16'd1280;
      target_distance <= 13'd410;
      steer_gain      <= 16'd2560;
      wall_threshold  <= 13'd410;
    end else if (cfg_we) begin
      unique case (cfg_item.index)
        REG_CRUISE:    cruise_speed    <= cfg_item.data;
        REG_TARGET:    target_distance <= cfg_item.data[12:0];
        REG_GAIN:      steer_gain      <= cfg_item.data;
        REG_THRESHOLD: wall_threshold  <= cfg_item.data[12:0];
        default: ;
      endcase
    end
  end

  // stage 1: capture value and the two quadrant sines
  logic [12:0] value;
  logic [12:0] sin_r, sin_c;
  logic [1:0]  quad;
  logic        last;

  function automatic logic [12:0] quad_sine(input logic [QB:0] pos);
    logic [QB-FB:0] idx;
    logic [FB-1:0]  frac;
    logic [12:0]    lo, d;
    logic [FB+12:0] p;
    idx  = pos[QB:FB];
    frac = pos[FB-1:0];
    lo   = sine_table(6'(idx));
    d    = sine_table(6'(idx) + 6'd1) - lo;
    p    = (FB + 13)'(d) * (FB + 13)'(frac) + (FB + 13)'(1 << (FB - 1));
    if (idx >= (QB - FB + 1)'(32)) return 13'd4096;
    return lo + 13'(p >> FB);
  endfunction

  logic [ANGLE_BITS-1:0] ang;
  logic [QB-1:0]         rpos;
  assign ang  = in_item.reading_angle[ANGLE_BITS-1:0];
  assign rpos = ang[QB-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= (in_item.reading_value > 13'd4096) ? 13'd4096 : in_item.reading_value;
      quad  <= ang[ANGLE_BITS-1 -: 2];
      last  <= in_item.last_reading;
      sin_r <= quad_sine({1'b0, rpos});
      sin_c <= quad_sine((QB + 1)'(1 << QB) - {1'b0, rpos});
    end
  end

  // stage 2: scale, sign, accumulate
  logic signed [19:0] sum_x, sum_y;
  logic [12:0]        peak_reading;
  logic [CW-1:0]      reading_count;
  logic [25:0]        px, py;
  logic [12:0]        mx_mag, my_mag, mag_x, mag_y;
  logic               neg_x, neg_y;

  always_comb begin
    unique case (quad)
      2'd0: begin mag_x = sin_c; mag_y = sin_r; neg_x = 1'b0; neg_y = 1'b0; end
      2'd1: begin mag_x = sin_r; mag_y = sin_c; neg_x = 1'b1; neg_y = 1'b0; end
      2'd2: begin mag_x = sin_c; mag_y = sin_r; neg_x = 1'b1; neg_y = 1'b1; end
      default: begin mag_x = sin_r; mag_y = sin_c; neg_x = 1'b0; neg_y = 1'b1; end
    endcase
    px = value * mag_x + 26'd2048;
    py = value * mag_y + 26'd2048;
    mx_mag = px[24:12];
    my_mag = py[24:12];
  end

  assign status.take = (reading_count < CW'(MAX_READINGS));
  assign status.last = last;
  assign status.wall = (peak_reading >= wall_threshold);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum_x         <= '0;
      sum_y         <= '0;
      peak_reading  <= '0;
      reading_count <= '0;
    end else if (cmd.accum) begin
      sum_x <= neg_x ? sum_x - 20'(mx_mag) : sum_x + 20'(mx_mag);
      sum_y <= neg_y ? sum_y - 20'(my_mag) : sum_y + 20'(my_mag);
      if (value > peak_reading) peak_reading <= value;
      reading_count <= reading_count + CW'(1);
    end
  end

  // restoring divider, both components in lockstep, one bit a cycle
  logic [19:0] qx, qy, rx, ry;
  logic [19:0] nx, ny;
  logic        sx, sy;
  logic [20:0] tx, ty;
  logic [CW-1:0] half;
  assign half = reading_count >> 1;
  assign nx = sum_x[19] ? 20'(-sum_x) : 20'(sum_x);
  assign ny = sum_y[19] ? 20'(-sum_y) : 20'(sum_y);
  assign tx = {rx, qx[19]} - 21'(reading_count);
  assign ty = {ry, qy[19]} - 21'(reading_count);

  logic signed [14:0] mean_x, mean_y;
  logic [28:0] sq, sq_next_x, sq_y_term;

  assign sq_y_term = 29'($unsigned(29'(mean_y) * 29'(mean_y)));
  assign sq        = sq_next_x + sq_y_term;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sx <= sum_x[19];
      sy <= sum_y[19];
      qx <= nx + 20'(half);
      qy <= ny + 20'(half);
      rx <= '0;
      ry <= '0;
    end else if (cmd.div_step) begin
      if (!tx[20]) begin rx <= tx[19:0]; qx <= {qx[18:0], 1'b1}; end
      else begin rx <= {rx[18:0], qx[19]}; qx <= {qx[18:0], 1'b0}; end
      if (!ty[20]) begin ry <= ty[19:0]; qy <= {qy[18:0], 1'b1}; end
      else begin ry <= {ry[18:0], qy[19]}; qy <= {qy[18:0], 1'b0}; end
    end
    if (cmd.div_end) begin
      mean_x <= sx ? -$signed({1'b0, qx[13:0]}) : $signed({1'b0, qx[13:0]});
      mean_y <= sy ? -$signed({1'b0, qy[13:0]}) : $signed({1'b0, qy[13:0]});
    end
    if (cmd.sq_x) sq_next_x <= 29'($unsigned(29'(mean_x) * 29'(mean_x)));
  end

  // bit-pair square root, one result bit a cycle
  logic [29:0] rem, rt;
  logic [29:0] rbit;
  logic [29:0] trial;
  assign trial = rt + rbit;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rem  <= 30'(sq);
      rt   <= '0;
      rbit <= 30'(1) << 28;
    end else if (cmd.sqrt_step) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        rt  <= (rt >> 1) + rbit;
      end else begin
        rt <= rt >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  // error, gain product, rounded correction, clamped speeds
  logic signed [16:0] err;
  logic signed [33:0] prod;
  logic [32:0]        pmag;
  logic [21:0]        corr_mag;
  logic signed [23:0] left_s, right_s;

  always_comb begin
    pmag     = prod[33] ? 33'(-prod) : 33'(prod);
    corr_mag = 22'((pmag + 33'd2048) >> 12);
    left_s   = prod[33] ? 24'(cruise_speed) + 24'(corr_mag)
                        : 24'(cruise_speed) - 24'(corr_mag);
    right_s  = prod[33] ? 24'(cruise_speed) - 24'(corr_mag)
                        : 24'(cruise_speed) + 24'(corr_mag);
  end

  function automatic logic [15:0] clamp(input logic signed [23:0] s);
    if (s < 0) return 16'd0;
    if (s > 24'sd65535) return 16'hFFFF;
    return s[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.fin_err)
      err <= $signed({2'b0, 15'(rt) + 15'((rem > rt) ? 1 : 0)}) -
             $signed({4'b0, target_distance});
    if (cmd.fin_mul) prod <= $signed({18'b0, steer_gain}) * 34'(err);
    if (cmd.fin_out) begin
      out_item.wall_seen <= status.wall;
      if (status.wall) begin
        out_item.left_speed  <= clamp(left_s);
        out_item.right_speed <= clamp(right_s);
      end else begin
        out_item.left_speed  <= cruise_speed;
        out_item.right_speed <= cruise_speed;
      end
    end
  end

endmodule

### hdl/proximity_wall_follow_controller_unit.sv
// Top level of the proportional wall-following controller.
// Joins pwfc_ctrl and pwfc_datapath; uses pwfc_pkg.
//
// Each reading passes through capture, then accumulate. For a reading marked
// last with a wall in view, the result is offered after a 20-step restoring
// divider for the means, run for both components in lockstep, a 15-step
// bit-pair square root, and error, gain multiply and clamp stages. A set with
// no wall goes from its check straight to the speed build. One item is
// in flight at a time and input stays blocked until the result is taken.
// Config writes are taken any cycle; make them only while no set is open.
module proximity_wall_follow_controller_unit #(
  parameter int MAX_READINGS = pwfc_pkg::MAX_READINGS_DEF,
  parameter int ANGLE_BITS   = pwfc_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pwfc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pwfc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  pwfc_pkg::cfg_item_t cfg_data
);
  import pwfc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  pwfc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .cmd
  );

  pwfc_datapath #(.MAX_READINGS(MAX_READINGS), .ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk, .rst, .in_item(in_data), .cfg_item(cfg_data),
    .cfg_we(cfg_valid & cfg_ready), .cmd, .status, .out_item(out_data)
  );

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.accum, cmd.div_step, cmd.sqrt_step, cmd.fin_out}))
    else $error("overlapping datapath commands");

endmodule
